[sv/opr_pkg.sv]
// ----------------------------------------------------------------------------
// opr_pkg: shared codes for the ordered pair relation table
// command kinds, status codes and cell control word
// ----------------------------------------------------------------------------
package opr_pkg;

    localparam logic [2:0] KIND_INSERT      = 3'd0;
    localparam logic [2:0] KIND_DROP_GROUP  = 3'd1;
    localparam logic [2:0] KIND_DROP_MEMBER = 3'd2;
    localparam logic [2:0] KIND_DROP_PAIR   = 3'd3;
    localparam logic [2:0] KIND_COUNT       = 3'd4;
    localparam logic [2:0] KIND_LIST        = 3'd5;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_NONE = 2'd2;

    // cell movement modes
    localparam logic [1:0] MODE_HOLD = 2'd0;
    localparam logic [1:0] MODE_DOWN = 2'd1;
    localparam logic [1:0] MODE_UP   = 2'd2;

    // most list results one command gives
    localparam int          MAX_OUT   = 64;
    localparam int          LIST_W    = 7;
    localparam logic [6:0]  COUNT_MAX = 7'd127;

    typedef struct packed {
        logic [1:0] mode;
        logic       load_en;
    } cell_ctl_t;

endpackage

[sv/ordered_pair_relation_table.sv]
// ----------------------------------------------------------------------------
// ordered_pair_relation_table: many-to-many relation list
// ordered chain of (group, member) pairs, newest in cell 0, with insert,
// drop by group / member / pair, count and list of a group's members
// ----------------------------------------------------------------------------
//
//  channel   signals                                  handshake
//  -------   ---------------------------------------  -------------------------
//  command   kind, group_id, member_id                taken when start && !busy
//  result    status, match_count, listed_member, last one cycle under done
//
//  insert: accept moves the sequencer to its final state, which registers the word
//  other kinds: the chain rotates one cell per cycle through the head, so a
//    command holds busy over the rotation and the final state; its final word follows
//  list words come out during the rotation, one cycle each, final has last
//  reset empties the table through the occupancy count, cell contents stay
//  the receiver cannot stall; kind codes 6 and 7 give no word and no change
//
module ordered_pair_relation_table #(
    parameter int ENTRIES     = 64,
    parameter int GROUP_BITS  = 8,
    parameter int MEMBER_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] kind,
    input  logic [7:0] group_id,
    input  logic [7:0] member_id,
    output logic       done,
    output logic [1:0] status,
    output logic [6:0] match_count,
    output logic [7:0] listed_member,
    output logic       last
);

    localparam int DATA_W = GROUP_BITS + MEMBER_BITS;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int HX_W   = CNT_W + 8;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PASS = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [2:0]             kind_reg, kind_next;
    logic [GROUP_BITS-1:0]  g_reg, g_next;
    logic [MEMBER_BITS-1:0] m_reg, m_next;
    logic [CNT_W-1:0]       occ_reg, occ_next;
    logic [CNT_W-1:0]       step_reg, step_next;
    logic [CNT_W-1:0]       hits_reg, hits_next;
    logic                   full_reg, full_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [MEMBER_BITS-1:0] pend_reg, pend_next;
    logic [opr_pkg::LIST_W-1:0] listed_reg, listed_next;

    // result word registers
    logic       done_reg, done_next;
    logic [1:0] status_reg, status_next;
    logic [6:0] count_reg, count_next;
    logic [7:0] member_reg, member_next;
    logic       last_reg, last_next;

    // ids cut or zero-extended to the stored widths
    logic [39:0]            gx, mx;
    logic [GROUP_BITS-1:0]  g_in;
    logic [MEMBER_BITS-1:0] m_in;

    assign gx   = {32'b0, group_id};
    assign mx   = {32'b0, member_id};
    assign g_in = gx[GROUP_BITS-1:0];
    assign m_in = mx[MEMBER_BITS-1:0];

    // the chain
    logic [DATA_W-1:0]  cell_data [ENTRIES];
    opr_pkg::cell_ctl_t cell_ctl;
    logic [IDX_W-1:0]   load_pos;
    logic [DATA_W-1:0]  new_pair;
    logic [DATA_W-1:0]  head;

    assign new_pair = {g_in, m_in};
    assign head     = cell_data[0];

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            logic [DATA_W-1:0] prev_d, next_d;
            if (gi == 0)
            begin : g_first
                assign prev_d = new_pair;
            end
            else
            begin : g_mid
                assign prev_d = cell_data[gi-1];
            end
            if (gi == ENTRIES - 1)
            begin : g_tail
                assign next_d = '0;
            end
            else
            begin : g_body
                assign next_d = cell_data[gi+1];
            end
            opr_cell #(
                .DATA_W (DATA_W),
                .IDX_W  (IDX_W),
                .IDX    (gi)
            ) u_cell (
                .clk       (clk),
                .ctl       (cell_ctl),
                .pos       (load_pos),
                .prev_data (prev_d),
                .next_data (next_d),
                .load_data (head),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    // head pair compare
    logic [GROUP_BITS-1:0]  head_g;
    logic [MEMBER_BITS-1:0] head_m;
    logic                   g_hit, m_hit;
    logic                   remove, count_hit, list_hit;
    logic                   is_drop;
    logic [CNT_W-1:0]       removed_sofar;

    assign head_g = head[DATA_W-1:MEMBER_BITS];
    assign head_m = head[MEMBER_BITS-1:0];
    assign g_hit  = (head_g == g_reg);
    assign m_hit  = (head_m == m_reg);

    always_comb
    begin
        case (kind_reg)
            opr_pkg::KIND_DROP_GROUP:  remove = g_hit;
            opr_pkg::KIND_DROP_MEMBER: remove = m_hit;
            opr_pkg::KIND_DROP_PAIR:   remove = g_hit && m_hit && (hits_reg == '0);
            default:                   remove = 1'b0;
        endcase
    end

    assign is_drop = (kind_reg == opr_pkg::KIND_DROP_GROUP) ||
                     (kind_reg == opr_pkg::KIND_DROP_MEMBER) ||
                     (kind_reg == opr_pkg::KIND_DROP_PAIR);
    assign count_hit = remove || ((kind_reg == opr_pkg::KIND_COUNT) && g_hit);
    assign list_hit  = (kind_reg == opr_pkg::KIND_LIST) && g_hit &&
                       (listed_reg < opr_pkg::LIST_W'(opr_pkg::MAX_OUT));
    assign removed_sofar = is_drop ? hits_reg : '0;

    // kept pairs land just above the block already kept
    logic [CNT_W-1:0] pos_full;
    assign pos_full = occ_reg - CNT_W'(1) - removed_sofar;
    assign load_pos = pos_full[IDX_W-1:0];

    // saturated count and member of the pending list word
    logic [HX_W-1:0]        hx;
    logic [6:0]             hits_sat;
    logic [MEMBER_BITS+7:0] pend_x;

    assign hx       = HX_W'(hits_reg);
    assign hits_sat = (hx > HX_W'(opr_pkg::COUNT_MAX)) ? opr_pkg::COUNT_MAX : hx[6:0];
    assign pend_x   = {8'b0, pend_reg};

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        g_next          = g_reg;
        m_next          = m_reg;
        occ_next        = occ_reg;
        step_next       = step_reg;
        hits_next       = hits_reg;
        full_next       = full_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        listed_next     = listed_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        count_next      = count_reg;
        member_next     = member_reg;
        last_next       = last_reg;
        cell_ctl.mode    = opr_pkg::MODE_HOLD;
        cell_ctl.load_en = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next       = kind;
                    g_next          = g_in;
                    m_next          = m_in;
                    hits_next       = '0;
                    step_next       = '0;
                    pend_valid_next = 1'b0;
                    listed_next     = '0;
                    if (kind == opr_pkg::KIND_INSERT)
                    begin
                        // insert happens right at accept
                        if (occ_reg < CNT_W'(ENTRIES))
                        begin
                            cell_ctl.mode = opr_pkg::MODE_DOWN;
                            occ_next      = occ_reg + CNT_W'(1);
                            full_next     = 1'b0;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                        state_next = ST_FIN;
                    end
                    else if (kind <= opr_pkg::KIND_LIST)
                    begin
                        state_next = (occ_reg == '0) ? ST_FIN : ST_PASS;
                    end
                end
            end

            ST_PASS:
            begin
                // rotate: head leaves cell 0, kept pairs are written back
                cell_ctl.mode    = opr_pkg::MODE_UP;
                cell_ctl.load_en = !remove;
                if (count_hit)
                    hits_next = hits_reg + CNT_W'(1);
                if (list_hit)
                begin
                    listed_next = listed_reg + opr_pkg::LIST_W'(1);
                    if (pend_valid_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = opr_pkg::STATUS_OK;
                        count_next  = 7'd0;
                        member_next = pend_x[7:0];
                        last_next   = 1'b0;
                    end
                    pend_next       = head_m;
                    pend_valid_next = 1'b1;
                end
                step_next = step_reg + CNT_W'(1);
                if (step_reg == occ_reg - CNT_W'(1))
                    state_next = ST_FIN;
            end

            ST_FIN:
            begin
                done_next   = 1'b1;
                status_next = opr_pkg::STATUS_OK;
                count_next  = 7'd0;
                member_next = 8'd0;
                last_next   = 1'b1;
                case (kind_reg)
                    opr_pkg::KIND_INSERT:
                    begin
                        if (full_reg)
                            status_next = opr_pkg::STATUS_FULL;
                    end
                    opr_pkg::KIND_DROP_GROUP, opr_pkg::KIND_DROP_MEMBER,
                    opr_pkg::KIND_COUNT:
                    begin
                        count_next = hits_sat;
                    end
                    opr_pkg::KIND_DROP_PAIR:
                    begin
                        if (hits_reg != '0)
                            count_next = 7'd1;
                        else
                            status_next = opr_pkg::STATUS_NONE;
                    end
                    opr_pkg::KIND_LIST:
                    begin
                        if (pend_valid_reg)
                            member_next = pend_x[7:0];
                        else
                            status_next = opr_pkg::STATUS_NONE;
                    end
                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
                if (is_drop)
                    occ_next = occ_reg - hits_reg;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            done_reg       <= done_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload and per-command working registers
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        g_reg      <= g_next;
        m_reg      <= m_next;
        step_reg   <= step_next;
        hits_reg   <= hits_next;
        full_reg   <= full_next;
        pend_reg   <= pend_next;
        listed_reg <= listed_next;
        status_reg <= status_next;
        count_reg  <= count_next;
        member_reg <= member_next;
        last_reg   <= last_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign match_count   = count_reg;
    assign listed_member = member_reg;
    assign last          = last_reg;

endmodule

[sv/opr_cell.sv]
// ----------------------------------------------------------------------------
// opr_cell: one slot of the pair chain
// holds one (group, member) pair, shifts toward either neighbor or loads
// the broadcast head pair when its position is selected
// ----------------------------------------------------------------------------
module opr_cell #(
    parameter int DATA_W = 16,
    parameter int IDX_W  = 6,
    parameter int IDX    = 0
) (
    input  logic                clk,
    input  opr_pkg::cell_ctl_t  ctl,
    input  logic [IDX_W-1:0]    pos,
    input  logic [DATA_W-1:0]   prev_data,
    input  logic [DATA_W-1:0]   next_data,
    input  logic [DATA_W-1:0]   load_data,
    output logic [DATA_W-1:0]   data
);

    localparam logic [IDX_W-1:0] MY_POS = IDX_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        case (ctl.mode)
            opr_pkg::MODE_HOLD: data_next = data_reg;
            opr_pkg::MODE_DOWN: data_next = prev_data;
            opr_pkg::MODE_UP:
            begin
                if (ctl.load_en && (pos == MY_POS))
                    data_next = load_data;
                else
                    data_next = next_data;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[sv/opr_checker.sv]
// ----------------------------------------------------------------------------
// opr_checker: port-level checks for the ordered pair relation table
// watches command and result words over time
// ----------------------------------------------------------------------------
module opr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [2:0] kind,
    input logic       done,
    input logic [1:0] status,
    input logic [6:0] match_count,
    input logic [7:0] listed_member,
    input logic       last
);

    // a taken command with a known kind keeps the block busy
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == opr_pkg::KIND_INSERT ||
            kind == opr_pkg::KIND_DROP_GROUP || kind == opr_pkg::KIND_DROP_MEMBER ||
            kind == opr_pkg::KIND_DROP_PAIR || kind == opr_pkg::KIND_COUNT ||
            kind == opr_pkg::KIND_LIST)) |=> busy)
        else $error("command accepted but block not busy");

    // only list words come before the final word, while still busy
    a_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |-> (busy && status == opr_pkg::STATUS_OK && match_count == 7'd0))
        else $error("bad non-final result word");

    // the final word frees the block
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last) |-> !busy)
        else $error("final word while busy");

    // a full table answer carries no count and no member
    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == opr_pkg::STATUS_FULL) |->
            (match_count == 7'd0 && listed_member == 8'd0 && last))
        else $error("bad table full word");

endmodule

bind ordered_pair_relation_table opr_checker u_opr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .done          (done),
    .status        (status),
    .match_count   (match_count),
    .listed_member (listed_member),
    .last          (last)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: ordered pair relation table
// sends table commands over start / busy, works out every result word from
// a local copy of the pair chain and checks each word under done in order
// ----------------------------------------------------------------------------
module testbench;

    localparam int ENTRIES          = 64;
    localparam int QUIET_LIMIT      = 1000;         // cycles with no command taken, no word
    localparam int DRAIN_CYCLES     = ENTRIES + 16; // longest rotation plus margin
    localparam int RANDOM_PER_PHASE = 28;
    localparam int FILL_INSERTS     = ENTRIES + 3;  // runs into a full table from any start
    localparam int REPORT_LIMIT     = 10;
    localparam int DIRECTED_ROWS    = 22;

    // kind codes the block ignores
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    // group used to fill the table in one block
    localparam logic [7:0] BULK_GROUP = 8'hA5;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] match_count;
        logic [7:0] listed_member;
        logic       last;
    } result_word_t;

    typedef struct packed {
        logic [2:0]   kind;
        logic [7:0]   group_id;
        logic [7:0]   member_id;
        logic         typed;    // word below is the known answer
        result_word_t word;
    } command_t;

    // ------------------------------------------------------------------------
    // clock and block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic [2:0] kind      = opr_pkg::KIND_INSERT;
    logic [7:0] group_id  = 8'd0;
    logic [7:0] member_id = 8'd0;
    logic       busy;
    logic       done;
    logic [1:0] status;
    logic [6:0] match_count;
    logic [7:0] listed_member;
    logic       last;

    // travel next to the command word, so the checker sees them at the same edge
    logic         cmd_typed = 1'b0;
    result_word_t cmd_word  = '0;

    result_word_t observed_word;
    assign observed_word = {status, match_count, listed_member, last};

    always #5 clk = ~clk;

    ordered_pair_relation_table #(
        .ENTRIES     (ENTRIES),
        .GROUP_BITS  (8),
        .MEMBER_BITS (8)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .group_id      (group_id),
        .member_id     (member_id),
        .done          (done),
        .status        (status),
        .match_count   (match_count),
        .listed_member (listed_member),
        .last          (last)
    );

    // ------------------------------------------------------------------------
    // table model: slot 0 holds the newest pair, slots 0..chain_fill-1 valid
    // ------------------------------------------------------------------------
    logic [7:0]   chain_group  [ENTRIES];
    logic [7:0]   chain_member [ENTRIES];
    int           chain_fill = 0;
    result_word_t awaited_words [$];    // words still owed by the block, oldest first

    int fault_count  = 0;
    int quiet_cycles = 0;

    function automatic result_word_t make_word(input logic [1:0] st, input logic [6:0] cnt,
                                               input logic [7:0] mem, input logic lst);
        result_word_t w;
        w.status        = st;
        w.match_count   = cnt;
        w.listed_member = mem;
        w.last          = lst;
        return w;
    endfunction

    // updates the model for one taken command and queues the words it owes
    function automatic void apply_table_command(input logic [2:0] k, input logic [7:0] g,
                                                input logic [7:0] m);
        int  wr;
        int  hits;
        int  hit_at;
        bit  hit;
        wr     = 0;
        hits   = 0;
        hit_at = -1;
        case (k)
            opr_pkg::KIND_INSERT:
            begin
                if (chain_fill >= ENTRIES)
                begin
                    // full table is left as it is
                    awaited_words.push_back(
                        make_word(opr_pkg::STATUS_FULL, 7'd0, 8'd0, 1'b1));
                end
                else
                begin
                    for (int i = chain_fill; i > 0; i--)
                    begin
                        chain_group[i]  = chain_group[i - 1];
                        chain_member[i] = chain_member[i - 1];
                    end
                    chain_group[0]  = g;
                    chain_member[0] = m;
                    chain_fill++;
                    awaited_words.push_back(
                        make_word(opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b1));
                end
            end
            opr_pkg::KIND_DROP_GROUP, opr_pkg::KIND_DROP_MEMBER:
            begin
                // squeeze out every hit, survivors keep their order
                for (int rd = 0; rd < chain_fill; rd++)
                begin
                    hit = (k == opr_pkg::KIND_DROP_GROUP) ? (chain_group[rd] == g)
                                                          : (chain_member[rd] == m);
                    if (hit)
                        hits++;
                    else
                    begin
                        chain_group[wr]  = chain_group[rd];
                        chain_member[wr] = chain_member[rd];
                        wr++;
                    end
                end
                chain_fill = wr;
                awaited_words.push_back(
                    make_word(opr_pkg::STATUS_OK, 7'(hits), 8'd0, 1'b1));
            end
            opr_pkg::KIND_DROP_PAIR:
            begin
                for (int i = 0; i < chain_fill; i++)
                    if (hit_at < 0 && chain_group[i] == g && chain_member[i] == m)
                        hit_at = i;
                if (hit_at < 0)
                    awaited_words.push_back(
                        make_word(opr_pkg::STATUS_NONE, 7'd0, 8'd0, 1'b1));
                else
                begin
                    for (int i = hit_at; i < chain_fill - 1; i++)
                    begin
                        chain_group[i]  = chain_group[i + 1];
                        chain_member[i] = chain_member[i + 1];
                    end
                    chain_fill--;
                    awaited_words.push_back(
                        make_word(opr_pkg::STATUS_OK, 7'd1, 8'd0, 1'b1));
                end
            end
            opr_pkg::KIND_COUNT:
            begin
                for (int i = 0; i < chain_fill; i++)
                    if (chain_group[i] == g)
                        hits++;
                awaited_words.push_back(
                    make_word(opr_pkg::STATUS_OK, 7'(hits), 8'd0, 1'b1));
            end
            opr_pkg::KIND_LIST:
            begin
                // newest first, one word per hit, final one marked
                for (int i = 0; i < chain_fill && hits < opr_pkg::MAX_OUT; i++)
                    if (chain_group[i] == g)
                    begin
                        awaited_words.push_back(
                            make_word(opr_pkg::STATUS_OK, 7'd0, chain_member[i], 1'b0));
                        hits++;
                    end
                if (hits == 0)
                    awaited_words.push_back(
                        make_word(opr_pkg::STATUS_NONE, 7'd0, 8'd0, 1'b1));
                else
                    awaited_words[awaited_words.size() - 1].last = 1'b1;
            end
            default:
            begin
                // spare kinds: no word, no change
            end
        endcase
    endfunction

    task automatic report_fault(input string what, input result_word_t want,
                                input result_word_t got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%0t %s: expected status=%0d count=%0d member=%0d last=%0d, %s%0d %s%0d %s%0d %s%0d",
                     $time, what, want.status, want.match_count, want.listed_member,
                     want.last, "got status=", got.status, "count=", got.match_count,
                     "member=", got.listed_member, "last=", got.last);
    endtask

    // ------------------------------------------------------------------------
    // checker: words are compared first, then the command taken at this edge
    // is run through the model; all values are the ones from before the edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_words.size() == 0)
                    report_fault("word with nothing awaited", '0, observed_word);
                else
                begin
                    want = awaited_words.pop_front();
                    if (observed_word.status !== want.status
                        || observed_word.match_count !== want.match_count
                        || observed_word.listed_member !== want.listed_member
                        || observed_word.last !== want.last)
                        report_fault("word mismatch", want, observed_word);
                end
            end

            if (start && !busy)
            begin
                apply_table_command(kind, group_id, member_id);
                // known answers from the table override the single model word
                if (cmd_typed)
                begin
                    void'(awaited_words.pop_back());
                    awaited_words.push_back(cmd_word);
                end
            end

            // watchdog: nothing moved on either side for too long
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // directed commands: empty table, extreme ids, every kind, spare kinds,
    // duplicate pairs, no-match cases; typed words where the answer is plain
    // ------------------------------------------------------------------------
    command_t directed_rows [DIRECTED_ROWS] = '{
        // kind, group, member, typed, status, count, member, last
        {opr_pkg::KIND_COUNT, 8'd0, 8'd0, 1'b1, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b1},
        {opr_pkg::KIND_LIST, 8'd0, 8'd0, 1'b1, opr_pkg::STATUS_NONE, 7'd0, 8'd0, 1'b1},
        {opr_pkg::KIND_DROP_PAIR, 8'd0, 8'd0, 1'b1, opr_pkg::STATUS_NONE, 7'd0, 8'd0, 1'b1},
        {opr_pkg::KIND_DROP_GROUP, 8'd255, 8'd0, 1'b1, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b1},
        {opr_pkg::KIND_DROP_MEMBER, 8'd0, 8'd255, 1'b1, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b1},
        {opr_pkg::KIND_INSERT, 8'd0, 8'd0, 1'b1, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b1},
        {opr_pkg::KIND_INSERT, 8'd255, 8'd255, 1'b1, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b1},
        {opr_pkg::KIND_INSERT, 8'd255, 8'd0, 1'b1, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b1},
        {opr_pkg::KIND_INSERT, 8'd0, 8'd255, 1'b1, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b1},
        {opr_pkg::KIND_INSERT, 8'd255, 8'd0, 1'b1, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b1},
        {KIND_SPARE_A, 8'd255, 8'd255, 1'b0, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b0},
        {opr_pkg::KIND_LIST, 8'd255, 8'd0, 1'b0, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b0},
        {opr_pkg::KIND_COUNT, 8'd255, 8'd0, 1'b0, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b0},
        {opr_pkg::KIND_DROP_PAIR, 8'd255, 8'd0, 1'b1, opr_pkg::STATUS_OK, 7'd1, 8'd0, 1'b1},
        {opr_pkg::KIND_LIST, 8'd255, 8'd255, 1'b0, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b0},
        {opr_pkg::KIND_DROP_PAIR, 8'h5A, 8'hA5, 1'b1, opr_pkg::STATUS_NONE, 7'd0, 8'd0, 1'b1},
        {KIND_SPARE_B, 8'd0, 8'd0, 1'b0, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b0},
        {opr_pkg::KIND_DROP_MEMBER, 8'd255, 8'd0, 1'b0, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b0},
        {opr_pkg::KIND_DROP_GROUP, 8'd0, 8'd255, 1'b0, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b0},
        {opr_pkg::KIND_COUNT, 8'd0, 8'd0, 1'b1, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b1},
        {opr_pkg::KIND_LIST, 8'd255, 8'd0, 1'b0, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b0},
        {opr_pkg::KIND_INSERT, 8'h5A, 8'hA5, 1'b1, opr_pkg::STATUS_OK, 7'd0, 8'd0, 1'b1}
    };

    // mostly a small id pool so pairs collide, now and then the full range
    function automatic command_t random_command();
        command_t c;
        int       pick;
        c    = '0;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            c.kind = opr_pkg::KIND_INSERT;
        else if (pick < 46)
            c.kind = opr_pkg::KIND_DROP_GROUP;
        else if (pick < 54)
            c.kind = opr_pkg::KIND_DROP_MEMBER;
        else if (pick < 68)
            c.kind = opr_pkg::KIND_DROP_PAIR;
        else if (pick < 78)
            c.kind = opr_pkg::KIND_COUNT;
        else if (pick < 96)
            c.kind = opr_pkg::KIND_LIST;
        else
            c.kind = pick[0] ? KIND_SPARE_A : KIND_SPARE_B;
        c.group_id  = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 5)) : 8'($urandom);
        c.member_id = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        return c;
    endfunction

    // present one command word and hold it until taken
    task automatic send_command(input command_t c);
        kind      <= c.kind;
        group_id  <= c.group_id;
        member_id <= c.member_id;
        cmd_typed <= c.typed;
        cmd_word  <= c.word;
        start     <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // random sender gap after a taken command
    task automatic sender_gap(input int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_plain(input logic [2:0] k, input logic [7:0] g, input logic [7:0] m,
                              input int pct);
        command_t c;
        c           = '0;
        c.kind      = k;
        c.group_id  = g;
        c.member_id = m;
        send_command(c);
        sender_gap(pct);
    endtask

    // ------------------------------------------------------------------------
    // stimulus: reset, directed rows, then three random phases with sender
    // idling at 19, 55 and 0 percent; the first phase opens by filling the
    // table past full with one group, then lists and counts it, tries to
    // drop one pair of it and drops the whole group
    initial
    begin
        int       idle_pct [3];
        int       sent;
        command_t c;
        idle_pct = '{19, 55, 0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_command(directed_rows[i]);
            sender_gap(idle_pct[0]);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 0)
            begin
                // last few inserts hit a full table
                for (int i = 0; i < FILL_INSERTS; i++)
                    send_plain(opr_pkg::KIND_INSERT, BULK_GROUP, 8'($urandom),
                               idle_pct[phase]);
                send_plain(opr_pkg::KIND_LIST, BULK_GROUP, 8'd0, idle_pct[phase]);
                send_plain(opr_pkg::KIND_COUNT, BULK_GROUP, 8'd0, idle_pct[phase]);
                send_plain(opr_pkg::KIND_DROP_PAIR, BULK_GROUP, 8'($urandom),
                           idle_pct[phase]);
                send_plain(opr_pkg::KIND_DROP_GROUP, BULK_GROUP, 8'd0, idle_pct[phase]);
            end
            sent = 0;
            while (sent < RANDOM_PER_PHASE)
            begin
                c = random_command();
                send_command(c);
                sender_gap(idle_pct[phase]);
                if (c.kind != KIND_SPARE_A && c.kind != KIND_SPARE_B)
                    sent++;
            end
        end

        // wait out owed words, then give stray words time to show
        start <= 1'b0;
        @(posedge clk);
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && awaited_words.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
sv/opr_pkg.sv
sv/opr_cell.sv
sv/ordered_pair_relation_table.sv
sv/opr_checker.sv
sim/testbench.sv
